/* design/ctig_pkg.sv */
// shared types and constants for the capsule triangle index generator
package ctig_pkg;

  localparam int unsigned MAX_RING_SEGMENTS = 128;
  localparam int unsigned MAX_CAP_RINGS     = 32;

  localparam int unsigned NUM_W      = 15;
  localparam int unsigned CORNER_W   = 14;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned RING_CFG_W = 8;
  localparam int unsigned CAP_CFG_W  = 6;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_SEGMENTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_RINGS     = 1'b1;

  localparam int unsigned RING_MIN   = 3;
  localparam int unsigned CAP_MIN    = 2;
  localparam int unsigned RING_RESET = 32;
  localparam int unsigned CAP_RESET  = 8;

  typedef enum logic [2:0] {
    SEC_CYL,
    SEC_TOP_FAN,
    SEC_TOP_RING,
    SEC_TOP_JOIN,
    SEC_BOT_FAN,
    SEC_BOT_RING,
    SEC_BOT_JOIN,
    SEC_NONE
  } sec_e;

  typedef struct packed {
    sec_e sec;
    logic half;
  } ctig_tag_t;

endpackage

/* design/ctig_div.sv */
// pipelined restoring divider, one quotient bit per stage, splits a quad number into row and column
module ctig_div #(
  parameter int unsigned RingW = 8,
  parameter int unsigned QuotW = 5,
  parameter int unsigned RemW  = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [RingW-1:0]     ring_seg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [RemW-1:0]      rem_i,
  input  ctig_pkg::ctig_tag_t  tag_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [RemW-1:0]      rem_o,
  output logic [QuotW-1:0]     quot_o,
  output ctig_pkg::ctig_tag_t  tag_o
);
  import ctig_pkg::*;

  localparam int unsigned EW = RemW + RingW;

  logic              vld_q  [QuotW];
  logic [RemW-1:0]   rem_q  [QuotW];
  logic [QuotW-1:0]  quot_q [QuotW];
  ctig_tag_t         tag_q  [QuotW];
  logic [QuotW:0]    en;

  assign en[QuotW] = ready_i;

  for (genvar j = 0; j < QuotW; j++) begin : g_stage
    localparam int unsigned K = QuotW - 1 - j;

    logic             vin;
    logic [RemW-1:0]  rin;
    logic [QuotW-1:0] qin;
    ctig_tag_t        tin;
    logic [EW-1:0]    dvs;
    logic [EW-1:0]    rext;
    logic             ge;
    logic [RemW-1:0]  rem_d;
    logic [QuotW-1:0] quot_d;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign rin = rem_i;
      assign qin = '0;
      assign tin = tag_i;
    end else begin : g_next
      assign vin = vld_q[j-1];
      assign rin = rem_q[j-1];
      assign qin = quot_q[j-1];
      assign tin = tag_q[j-1];
    end

    assign en[j] = !vld_q[j] || en[j+1];

    always_comb begin
      dvs    = EW'(ring_seg_i) << K;
      rext   = EW'(rin);
      ge     = (rext >= dvs);
      rem_d  = ge ? RemW'(rext - dvs) : rin;
      quot_d = qin;
      quot_d[K] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en[j]) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j] && vin) begin
        rem_q[j]  <= rem_d;
        quot_q[j] <= quot_d;
        tag_q[j]  <= tin;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[QuotW-1];
  assign rem_o   = rem_q[QuotW-1];
  assign quot_o  = quot_q[QuotW-1];
  assign tag_o   = tag_q[QuotW-1];

endmodule

/* design/capsule_triangle_index_generator.sv */
// Capsule triangle index generator: takes a triangle number and returns the three vertex
// indices of that triangle in the capsule mesh (two cylinder rings, then pole and latitude
// rings of each cap), with in_range_o low and zero corners past the last triangle. One word
// is taken every cycle while stall_o is low; each word passes through the pipeline stages
// in order (section compare, offset subtract, one restoring divider stage per quotient bit
// for the ring and column split, row multiply, row base add, corner add). Empty stages close
// up under stall_i, so input words keep flowing while a finished word waits at the output.
// Write ring_segments and cap_rings only while no word is in flight; out-of-range writes are
// clamped to 3..MaxRingSegments and 2..MaxCapRings.
module capsule_triangle_index_generator #(
  parameter int unsigned MaxRingSegments = ctig_pkg::MAX_RING_SEGMENTS,
  parameter int unsigned MaxCapRings     = ctig_pkg::MAX_CAP_RINGS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ctig_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ctig_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [ctig_pkg::NUM_W-1:0]          triangle_number_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [ctig_pkg::CORNER_W-1:0]       corner_a_o,
  output logic [ctig_pkg::CORNER_W-1:0]       corner_b_o,
  output logic [ctig_pkg::CORNER_W-1:0]       corner_c_o,
  output logic                                in_range_o
);
  import ctig_pkg::*;

  localparam int unsigned RW   = $clog2(MaxRingSegments + 1);
  localparam int unsigned LW   = $clog2(MaxCapRings + 1);
  localparam int unsigned RLW  = $clog2(MaxRingSegments * MaxCapRings + 1);
  localparam int unsigned CW0  =
    $clog2(8 * MaxRingSegments + 4 * MaxRingSegments * MaxCapRings + 1);
  localparam int unsigned CW   = (CW0 > NUM_W) ? CW0 : NUM_W;
  localparam int unsigned MW   = $clog2(2 * MaxRingSegments * MaxCapRings);
  localparam int unsigned QNW  = MW - 1;
  localparam int unsigned QW   = $clog2(MaxCapRings);
  localparam int unsigned XW0  = $clog2(2 * (MaxRingSegments + 1) * (MaxCapRings + 2) + 4);
  localparam int unsigned XW   = (XW0 > CORNER_W) ? XW0 : CORNER_W;
  localparam int unsigned CRW  = (RW > RING_CFG_W) ? RW : RING_CFG_W;
  localparam int unsigned CLW  = (LW > CAP_CFG_W) ? LW : CAP_CFG_W;

  localparam int unsigned RING_RST = (RING_RESET > MaxRingSegments) ? MaxRingSegments : RING_RESET;
  localparam int unsigned CAP_RST  = (CAP_RESET > MaxCapRings) ? MaxCapRings : CAP_RESET;
  localparam int unsigned RL_RST   = RING_RST * CAP_RST;

  // configuration
  logic [RW-1:0]  ring_q, ring_d;
  logic [LW-1:0]  cap_q, cap_d;
  logic [RLW-1:0] rl_q, rl_d;
  logic [CRW-1:0] ring_raw;
  logic [CLW-1:0] cap_raw;

  always_comb begin
    ring_raw = CRW'(cfg_data_i[RING_CFG_W-1:0]);
    cap_raw  = CLW'(cfg_data_i[CAP_CFG_W-1:0]);
    ring_d   = ring_q;
    cap_d    = cap_q;
    if (cfg_we_i && cfg_idx_i == CFG_RING_SEGMENTS) begin
      if (ring_raw < CRW'(RING_MIN)) begin
        ring_d = RW'(RING_MIN);
      end else if (ring_raw > CRW'(MaxRingSegments)) begin
        ring_d = RW'(MaxRingSegments);
      end else begin
        ring_d = RW'(ring_raw);
      end
    end
    if (cfg_we_i && cfg_idx_i == CFG_CAP_RINGS) begin
      if (cap_raw < CLW'(CAP_MIN)) begin
        cap_d = LW'(CAP_MIN);
      end else if (cap_raw > CLW'(MaxCapRings)) begin
        cap_d = LW'(MaxCapRings);
      end else begin
        cap_d = LW'(cap_raw);
      end
    end
    rl_d = RLW'(ring_d) * RLW'(cap_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= RW'(RING_RST);
      cap_q  <= LW'(CAP_RST);
      rl_q   <= RLW'(RL_RST);
    end else if (cfg_we_i) begin
      ring_q <= ring_d;
      cap_q  <= cap_d;
      rl_q   <= rl_d;
    end
  end

  // section boundaries in triangle order
  logic [CW-1:0] r_c, rl_c;
  logic [CW-1:0] bnd_top_fan, bnd_top_ring, bnd_top_join;
  logic [CW-1:0] bnd_bot_fan, bnd_bot_ring, bnd_bot_join, bnd_end;

  always_comb begin
    r_c          = CW'(ring_q);
    rl_c         = CW'(rl_q);
    bnd_top_fan  = r_c << 1;
    bnd_top_ring = r_c * CW'(3);
    bnd_top_join = r_c * CW'(3) + (rl_c << 1);
    bnd_bot_fan  = r_c * CW'(5) + (rl_c << 1);
    bnd_bot_ring = r_c * CW'(6) + (rl_c << 1);
    bnd_bot_join = r_c * CW'(6) + (rl_c << 2);
    bnd_end      = (r_c << 3) + (rl_c << 2);
  end

  // handshake enables, each stage moves when empty or when the next one moves
  logic en_s1, en_s2, en_sm, en_su, en_out;
  logic div_ready, div_valid;

  // stage 1: section
  logic          s1_vld_q;
  logic [CW-1:0] s1_num_q;
  sec_e          s1_sec_q;
  logic [CW-1:0] num_c;
  sec_e          sec_d;

  always_comb begin
    num_c = CW'(triangle_number_i);
    if (num_c < bnd_top_fan) begin
      sec_d = SEC_CYL;
    end else if (num_c < bnd_top_ring) begin
      sec_d = SEC_TOP_FAN;
    end else if (num_c < bnd_top_join) begin
      sec_d = SEC_TOP_RING;
    end else if (num_c < bnd_bot_fan) begin
      sec_d = SEC_TOP_JOIN;
    end else if (num_c < bnd_bot_ring) begin
      sec_d = SEC_BOT_FAN;
    end else if (num_c < bnd_bot_join) begin
      sec_d = SEC_BOT_RING;
    end else if (num_c < bnd_end) begin
      sec_d = SEC_BOT_JOIN;
    end else begin
      sec_d = SEC_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_s1) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s1 && valid_i) begin
      s1_num_q <= num_c;
      s1_sec_q <= sec_d;
    end
  end

  // stage 2: offset within the section
  logic            s2_vld_q;
  logic [QNW-1:0]  s2_q_q;
  ctig_tag_t       s2_tag_q;
  logic [CW-1:0]   base_c;
  logic [CW-1:0]   diff_c;
  logic [MW-1:0]   m_c;

  always_comb begin
    case (s1_sec_q)
      SEC_CYL:      base_c = '0;
      SEC_TOP_FAN:  base_c = bnd_top_fan;
      SEC_TOP_RING: base_c = bnd_top_ring;
      SEC_TOP_JOIN: base_c = bnd_top_join;
      SEC_BOT_FAN:  base_c = bnd_bot_fan;
      SEC_BOT_RING: base_c = bnd_bot_ring;
      SEC_BOT_JOIN: base_c = bnd_bot_join;
      default:      base_c = s1_num_q;
    endcase
    diff_c = s1_num_q - base_c;
    m_c    = diff_c[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_s2) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s2 && s1_vld_q) begin
      s2_q_q        <= m_c[MW-1:1];
      s2_tag_q.sec  <= s1_sec_q;
      s2_tag_q.half <= m_c[0];
    end
  end

  // quad number split into latitude row and column
  logic [QNW-1:0] div_rem;
  logic [QW-1:0]  div_quot;
  ctig_tag_t      div_tag;

  ctig_div #(
    .RingW (RW),
    .QuotW (QW),
    .RemW  (QNW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ring_seg_i (ring_q),
    .valid_i    (s2_vld_q),
    .ready_o    (div_ready),
    .rem_i      (s2_q_q),
    .tag_i      (s2_tag_q),
    .valid_o    (div_valid),
    .ready_i    (en_sm),
    .rem_o      (div_rem),
    .quot_o     (div_quot),
    .tag_o      (div_tag)
  );

  // stage m: row offset product and section base vertices
  logic [XW-1:0] rx, lx, rlx, vx;
  logic [XW-1:0] north_pole, top_first, lat_len, south_pole, bot_first;
  logic [XW-1:0] ubase_d, wbase_d, prod_d;

  logic           sm_vld_q;
  ctig_tag_t      sm_tag_q;
  logic [QNW-1:0] sm_rem_q;
  logic [XW-1:0]  sm_prod_q, sm_ubase_q, sm_wbase_q;

  always_comb begin
    rx         = XW'(ring_q);
    lx         = XW'(cap_q);
    rlx        = XW'(rl_q);
    vx         = rx + XW'(1);
    north_pole = (rx << 1) + XW'(2);
    top_first  = (rx << 1) + XW'(3);
    lat_len    = rlx + lx;
    south_pole = top_first + lat_len + vx;
    bot_first  = south_pole + XW'(1);
    prod_d     = XW'(div_quot) * vx;
    case (div_tag.sec)
      SEC_CYL: begin
        ubase_d = '0;
        wbase_d = vx;
      end
      SEC_TOP_FAN: begin
        ubase_d = north_pole;
        wbase_d = top_first;
      end
      SEC_TOP_RING: begin
        ubase_d = top_first;
        wbase_d = top_first + vx;
      end
      SEC_TOP_JOIN: begin
        ubase_d = top_first + lat_len;
        wbase_d = '0;
      end
      SEC_BOT_FAN: begin
        ubase_d = south_pole;
        wbase_d = bot_first;
      end
      SEC_BOT_RING: begin
        ubase_d = bot_first;
        wbase_d = bot_first + vx;
      end
      SEC_BOT_JOIN: begin
        ubase_d = bot_first + lat_len;
        wbase_d = vx;
      end
      default: begin
        ubase_d = '0;
        wbase_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_vld_q <= 1'b0;
    end else if (en_sm) begin
      sm_vld_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_sm && div_valid) begin
      sm_tag_q   <= div_tag;
      sm_rem_q   <= div_rem;
      sm_prod_q  <= prod_d;
      sm_ubase_q <= ubase_d;
      sm_wbase_q <= wbase_d;
    end
  end

  // stage u: upper and lower row starts, column
  logic          su_vld_q;
  ctig_tag_t     su_tag_q;
  logic [XW-1:0] su_u_q, su_w_q, su_col_q;
  logic [XW-1:0] col_d;

  always_comb begin
    // fan triangles count single steps, quads count pairs
    if (sm_tag_q.sec inside {SEC_TOP_FAN, SEC_BOT_FAN}) begin
      col_d = (XW'(sm_rem_q) << 1) | XW'(sm_tag_q.half);
    end else begin
      col_d = XW'(sm_rem_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_vld_q <= 1'b0;
    end else if (en_su) begin
      su_vld_q <= sm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_su && sm_vld_q) begin
      su_tag_q <= sm_tag_q;
      su_u_q   <= sm_ubase_q + sm_prod_q;
      su_w_q   <= sm_wbase_q + sm_prod_q;
      su_col_q <= col_d;
    end
  end

  // output stage: corners and winding
  logic          out_vld_q;
  logic [XW-1:0] qa, qb, qc, qd;
  logic [XW-1:0] ka_d, kb_d, kc_d;
  logic [CORNER_W-1:0] corner_a_q, corner_b_q, corner_c_q;
  logic          in_range_q;

  always_comb begin
    qa = su_u_q + su_col_q;
    qb = su_u_q + su_col_q + XW'(1);
    qc = su_w_q + su_col_q;
    qd = su_w_q + su_col_q + XW'(1);
    case (su_tag_q.sec)
      SEC_TOP_FAN: begin
        ka_d = su_u_q;
        kb_d = qc;
        kc_d = qd;
      end
      SEC_BOT_FAN: begin
        ka_d = su_u_q;
        kb_d = qd;
        kc_d = qc;
      end
      SEC_CYL, SEC_TOP_RING, SEC_TOP_JOIN: begin
        ka_d = su_tag_q.half ? qb : qa;
        kb_d = su_tag_q.half ? qd : qb;
        kc_d = qc;
      end
      SEC_BOT_RING, SEC_BOT_JOIN: begin
        ka_d = su_tag_q.half ? qb : qa;
        kb_d = qc;
        kc_d = su_tag_q.half ? qd : qb;
      end
      default: begin
        ka_d = '0;
        kb_d = '0;
        kc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_out) begin
      out_vld_q <= su_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && su_vld_q) begin
      corner_a_q <= ka_d[CORNER_W-1:0];
      corner_b_q <= kb_d[CORNER_W-1:0];
      corner_c_q <= kc_d[CORNER_W-1:0];
      in_range_q <= (su_tag_q.sec != SEC_NONE);
    end
  end

  assign en_out = !out_vld_q || !stall_i;
  assign en_su  = !su_vld_q || en_out;
  assign en_sm  = !sm_vld_q || en_su;
  assign en_s2  = !s2_vld_q || div_ready;
  assign en_s1  = !s1_vld_q || en_s2;

  assign stall_o    = !en_s1;
  assign valid_o    = out_vld_q;
  assign corner_a_o = corner_a_q;
  assign corner_b_o = corner_b_q;
  assign corner_c_o = corner_c_q;
  assign in_range_o = in_range_q;

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !in_range_o) |-> (corner_a_o == '0 && corner_b_o == '0 && corner_c_o == '0))
    else $error("out of range word with nonzero corners");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled while output free");

  a_rl_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rl_q == RLW'(RLW'(ring_q) * RLW'(cap_q)))
    else $error("ring product out of step with configuration");

  a_cfg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_q >= RW'(RING_MIN) && ring_q <= RW'(MaxRingSegments) &&
     cap_q >= LW'(CAP_MIN) && cap_q <= LW'(MaxCapRings)))
    else $error("configuration outside clamp range");

endmodule

/* tb/ctig_corner_checker.sv */
// watches the capsule triangle index generator ports, predicts each triangle's corners and compares
module ctig_corner_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ctig_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctig_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            num_valid_i,
  input  logic                            num_stall_i,
  input  logic [ctig_pkg::NUM_W-1:0]      num_i,
  input  logic                            tri_valid_i,
  input  logic                            tri_stall_i,
  input  logic [ctig_pkg::CORNER_W-1:0]   corner_a_i,
  input  logic [ctig_pkg::CORNER_W-1:0]   corner_b_i,
  input  logic [ctig_pkg::CORNER_W-1:0]   corner_c_i,
  input  logic                            in_range_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_count_o,
  output int unsigned                     checked_count_o,
  output int unsigned                     off_mesh_count_o,
  output int unsigned                     ring_segments_o,
  output int unsigned                     cap_rings_o
);
  import ctig_pkg::*;

  typedef struct packed {
    logic [CORNER_W-1:0] a;
    logic [CORNER_W-1:0] b;
    logic [CORNER_W-1:0] c;
    logic                in_range;
  } tri_corners_t;

  tri_corners_t pending_corners_q[$];
  int unsigned  ring_segments;
  int unsigned  cap_rings;
  int unsigned  fail_total;
  int unsigned  checked_total;
  int unsigned  off_mesh_total;

  // two triangles per quad between an upper ring u and a lower ring w
  function automatic tri_corners_t quad_corners(int unsigned u, int unsigned w, int unsigned col,
                                                logic second, logic flip);
    int unsigned  a, b, c, d;
    tri_corners_t t;
    a = u + col;
    b = a + 1;
    c = w + col;
    d = c + 1;
    t.in_range = 1'b1;
    if (!flip && !second) begin
      t.a = CORNER_W'(a); t.b = CORNER_W'(b); t.c = CORNER_W'(c);
    end else if (!flip) begin
      t.a = CORNER_W'(b); t.b = CORNER_W'(d); t.c = CORNER_W'(c);
    end else if (!second) begin
      t.a = CORNER_W'(a); t.b = CORNER_W'(c); t.c = CORNER_W'(b);
    end else begin
      t.a = CORNER_W'(b); t.b = CORNER_W'(c); t.c = CORNER_W'(d);
    end
    return t;
  endfunction

  function automatic tri_corners_t predict_corners(logic [NUM_W-1:0] num, int unsigned r,
                                                   int unsigned l);
    int unsigned  v, m, q, s, north_pole, top_first, south_pole, bot_first;
    int unsigned  sizes[7];
    sec_e         sec;
    tri_corners_t t;
    v          = r + 1;
    north_pole = 2 * v;
    top_first  = north_pole + 1;
    south_pole = top_first + (l + 1) * v;
    bot_first  = south_pole + 1;
    sizes      = '{2 * r, r, 2 * r * l, 2 * r, r, 2 * r * l, 2 * r};
    m          = 32'(num);
    sec        = SEC_NONE;
    // walk the sections in mesh order, leaving m as the offset inside its section
    for (s = 0; s < 7; s++) begin
      if (sec == SEC_NONE) begin
        if (m < sizes[s]) sec = sec_e'(s);
        else m -= sizes[s];
      end
    end
    q = m >> 1;
    t = '0;
    t.in_range = 1'b1;
    case (sec)
      SEC_CYL:      t = quad_corners(0, v, q, m[0], 1'b0);
      SEC_TOP_FAN: begin
        t.a = CORNER_W'(north_pole);
        t.b = CORNER_W'(top_first + m);
        t.c = CORNER_W'(top_first + m + 1);
      end
      SEC_TOP_RING: t = quad_corners(top_first + (q / r) * v, top_first + (q / r + 1) * v,
                                     q % r, m[0], 1'b0);
      SEC_TOP_JOIN: t = quad_corners(top_first + l * v, 0, q, m[0], 1'b0);
      SEC_BOT_FAN: begin
        t.a = CORNER_W'(south_pole);
        t.b = CORNER_W'(bot_first + m + 1);
        t.c = CORNER_W'(bot_first + m);
      end
      SEC_BOT_RING: t = quad_corners(bot_first + (q / r) * v, bot_first + (q / r + 1) * v,
                                     q % r, m[0], 1'b1);
      SEC_BOT_JOIN: t = quad_corners(bot_first + l * v, v, q, m[0], 1'b1);
      default:      t = '0;
    endcase
    return t;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tri_corners_t want;
    if (!rst_ni) begin
      pending_corners_q.delete();
      ring_segments  = RING_RESET;
      cap_rings      = CAP_RESET;
      fail_total     = 0;
      checked_total  = 0;
      off_mesh_total = 0;
    end else begin
      if (tri_valid_i && !tri_stall_i) begin
        if (pending_corners_q.size() == 0) begin
          $error("triangle word with no request outstanding");
          fail_total++;
        end else begin
          want = pending_corners_q.pop_front();
          check_field("corner_a", 32'(want.a), 32'(corner_a_i));
          check_field("corner_b", 32'(want.b), 32'(corner_b_i));
          check_field("corner_c", 32'(want.c), 32'(corner_c_i));
          check_field("in_range", 32'(want.in_range), 32'(in_range_i));
          checked_total++;
          if (!want.in_range) off_mesh_total++;
        end
      end
      if (num_valid_i && !num_stall_i)
        pending_corners_q = {pending_corners_q,
                             predict_corners(num_i, ring_segments, cap_rings)};
      // register writes clamp to the legal range
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RING_SEGMENTS) begin
          ring_segments = 32'(cfg_data_i[RING_CFG_W-1:0]);
          if (ring_segments < RING_MIN) ring_segments = RING_MIN;
          if (ring_segments > MAX_RING_SEGMENTS) ring_segments = MAX_RING_SEGMENTS;
        end else if (cfg_idx_i == CFG_CAP_RINGS) begin
          cap_rings = 32'(cfg_data_i[CAP_CFG_W-1:0]);
          if (cap_rings < CAP_MIN) cap_rings = CAP_MIN;
          if (cap_rings > MAX_CAP_RINGS) cap_rings = MAX_CAP_RINGS;
        end
      end
    end
    fail_count_o     <= fail_total;
    pending_count_o  <= pending_corners_q.size();
    checked_count_o  <= checked_total;
    off_mesh_count_o <= off_mesh_total;
    ring_segments_o  <= ring_segments;
    cap_rings_o      <= cap_rings;
  end

endmodule

/* tb/capsule_triangle_index_generator_tb.sv */
// stimulus and verdict for the capsule triangle index generator, checking done by ctig_corner_checker
module capsule_triangle_index_generator_tb;
  import ctig_pkg::*;

  localparam int unsigned PIPE_LATENCY = $clog2(MAX_CAP_RINGS) + 5;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned NUM_PHASES   = 8;

  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i         = CFG_RING_SEGMENTS;
  logic [CFG_DATA_W-1:0] cfg_data_i        = '0;
  logic                  valid_i           = 1'b0;
  logic [NUM_W-1:0]      triangle_number_i = '0;
  logic                  stall_i           = 1'b0;
  logic                  stall_o;
  logic                  valid_o;
  logic [CORNER_W-1:0]   corner_a_o;
  logic [CORNER_W-1:0]   corner_b_o;
  logic [CORNER_W-1:0]   corner_c_o;
  logic                  in_range_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned off_mesh_count;
  int unsigned cur_ring_segments;
  int unsigned cur_cap_rings;
  bit          calm = 1'b0;

  capsule_triangle_index_generator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .valid_i           (valid_i),
    .stall_o           (stall_o),
    .triangle_number_i (triangle_number_i),
    .valid_o           (valid_o),
    .stall_i           (stall_i),
    .corner_a_o        (corner_a_o),
    .corner_b_o        (corner_b_o),
    .corner_c_o        (corner_c_o),
    .in_range_o        (in_range_o)
  );

  ctig_corner_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .num_valid_i      (valid_i),
    .num_stall_i      (stall_o),
    .num_i            (triangle_number_i),
    .tri_valid_i      (valid_o),
    .tri_stall_i      (stall_i),
    .corner_a_i       (corner_a_o),
    .corner_b_i       (corner_b_o),
    .corner_c_i       (corner_c_o),
    .in_range_i       (in_range_o),
    .fail_count_o     (fail_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count),
    .off_mesh_count_o (off_mesh_count),
    .ring_segments_o  (cur_ring_segments),
    .cap_rings_o      (cur_cap_rings)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // first triangle number of section k, k = 7 gives the total count
  function automatic int unsigned section_start(int unsigned k, int unsigned r, int unsigned l);
    case (k)
      0:       return 0;
      1:       return 2 * r;
      2:       return 3 * r;
      3:       return 3 * r + 2 * r * l;
      4:       return 5 * r + 2 * r * l;
      5:       return 6 * r + 2 * r * l;
      6:       return 6 * r + 4 * r * l;
      default: return 8 * r + 4 * r * l;
    endcase
  endfunction

  task automatic send_number(int unsigned num);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i           <= 1'b1;
    triangle_number_i <= NUM_W'(num);
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    int unsigned total, sel, k, i, num;
    total = section_start(7, cur_ring_segments, cur_cap_rings);
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        num = $urandom_range(0, total - 1);
      end else if (sel < 88) begin
        // straddle a section boundary
        k   = $urandom_range(1, 7);
        num = section_start(k, cur_ring_segments, cur_cap_rings) - 1 + $urandom_range(0, 1);
      end else begin
        num = $urandom_range(total, (1 << NUM_W) - 1);
      end
      send_number(num);
    end
  endtask

  task automatic drain_words();
    int unsigned k;
    valid_i <= 1'b0;
    k = 0;
    do begin
      @(posedge clk_i);
      k++;
    end while (pending_count != 0 && k < DRAIN_LIMIT);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_config(logic [CFG_DATA_W-1:0] ring_data, logic [CFG_DATA_W-1:0] cap_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RING_SEGMENTS;
    cfg_data_i <= ring_data;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CAP_RINGS;
    cfg_data_i <= cap_data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // let the checker's view of the registers settle
    @(posedge clk_i);
  endtask

  // result side: stall_i is raised at random after a word, and now and then while idle too, never when calm
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (stall_i) begin
        hold = hold - 1;
        if (hold == 0) stall_i <= 1'b0;
      end else if (valid_o) begin
        hold = calm ? 0 : $urandom_range(0, 5);
        if (hold != 0) stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold    = $urandom_range(1, 5);
        stall_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned k, p;
    logic [CFG_DATA_W-1:0] ring_data, cap_data;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // section edges under the reset settings, including the first number past the mesh
    for (k = 0; k < 8; k++) begin
      if (k != 0) send_number(section_start(k, RING_RESET, CAP_RESET) - 1);
      send_number(section_start(k, RING_RESET, CAP_RESET));
    end
    send_number(1);
    send_number((1 << NUM_W) - 1);
    send_random(100);
    drain_words();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin ring_data = 8'd3;   cap_data = 8'd2;   end
        1:       begin ring_data = 8'd128; cap_data = 8'd32;  end
        2:       begin ring_data = 8'd0;   cap_data = 8'd0;   end
        3:       begin ring_data = 8'd255; cap_data = 8'd255; end
        4:       begin ring_data = 8'd200; cap_data = 8'h45;  end
        default: begin
          ring_data = CFG_DATA_W'($urandom_range(0, 255));
          cap_data  = CFG_DATA_W'($urandom_range(0, 255));
        end
      endcase
      calm = (p == 1 || p == 5);
      write_config(ring_data, cap_data);
      send_random(120);
      drain_words();
    end

    $display("checked %0d triangle words over %0d register settings",
             checked_count, NUM_PHASES + 1);
    $display("%0d of them past the end of the mesh", off_mesh_count);
    if (pending_count != 0) $error("%0d triangle words never came out", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $error("run timed out");
    $display("Some tests failed");
    $finish;
  end

endmodule
